// ===== hdl/double_hash_table_tombstone_core_assert.svh =====
// assertion macros for the double hash table core
`ifndef DOUBLE_HASH_TABLE_TOMBSTONE_CORE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_TOMBSTONE_CORE_ASSERT_SVH

// clocked check, off while reset is held
`define DHTT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define DHTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/dhtt_pkg.sv =====
// types, constants and hash helpers for the double hash table core
`timescale 1ns / 1ps

package dhtt_pkg;

  // table geometry (the step prime must not exceed the table size)
  localparam int TABLE_SIZE = 23;
  localparam int STEP_PRIME = 19;
  localparam int KEY_W      = 31;
  localparam int ELEM_W     = 31;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int PRES_W = $clog2(STEP_PRIME);
  localparam int STEP_W = $clog2(STEP_PRIME + 1);
  localparam int SUM_W  = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;

  // key is reduced two bits per cycle
  localparam int HASH_STEPS = (KEY_W + 1) / 2;
  localparam int HKEY_W     = 2 * HASH_STEPS;
  localparam int HCNT_W     = $clog2(HASH_STEPS);

  // operation codes
  localparam logic [1:0] FUNC_FIND   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // result codes
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_DUPLICATE = 2'd2;
  localparam logic [1:0] RES_FULL      = 2'd3;

  // slot codes
  localparam logic [1:0] SLOT_NEVER    = 2'd0;
  localparam logic [1:0] SLOT_DELETED  = 2'd1;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [ELEM_W-1:0] elem_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] elem_out;
  } rsp_t;

  // write port of the slot store
  typedef struct packed {
    logic              st_we;
    logic              kv_we;
    logic [IDX_W-1:0]  addr;
    logic [1:0]        status;
    logic [KEY_W-1:0]  key;
    logic [ELEM_W-1:0] value;
  } wr_t;

  // registered read data of the slot store
  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  key;
    logic [ELEM_W-1:0] value;
  } rd_t;

  // hash unit result
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  home;
    logic [STEP_W-1:0] step;
  } hash_t;

  // one radix-4 step of key mod table size
  function automatic logic [IDX_W-1:0] mod_n_step(input logic [IDX_W-1:0] r,
                                                 input logic [1:0] d);
    logic [IDX_W+1:0] t;
    t = {r, d};
    if (t >= (IDX_W+2)'(2 * TABLE_SIZE)) t = t - (IDX_W+2)'(2 * TABLE_SIZE);
    if (t >= (IDX_W+2)'(TABLE_SIZE)) t = t - (IDX_W+2)'(TABLE_SIZE);
    return t[IDX_W-1:0];
  endfunction

  // one radix-4 step of key mod step prime
  function automatic logic [PRES_W-1:0] mod_p_step(input logic [PRES_W-1:0] r,
                                                  input logic [1:0] d);
    logic [PRES_W+1:0] t;
    t = {r, d};
    if (t >= (PRES_W+2)'(2 * STEP_PRIME)) t = t - (PRES_W+2)'(2 * STEP_PRIME);
    if (t >= (PRES_W+2)'(STEP_PRIME)) t = t - (PRES_W+2)'(STEP_PRIME);
    return t[PRES_W-1:0];
  endfunction

  // advance a probe position by the step, wrapping at the table size
  function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos,
                                               input logic [STEP_W-1:0] step);
    logic [SUM_W-1:0] s;
    s = SUM_W'(pos) + SUM_W'(step);
    if (s >= SUM_W'(TABLE_SIZE)) s = s - SUM_W'(TABLE_SIZE);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/dhtt_hash.sv =====
// iterative home slot and probe step unit, two key bits per cycle
`timescale 1ns / 1ps

module dhtt_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dhtt_pkg::KEY_W-1:0] key_i,
  output dhtt_pkg::hash_t            hash_o
);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [dhtt_pkg::HCNT_W-1:0]   cnt_q, cnt_d;
  logic [dhtt_pkg::HKEY_W-1:0]   k_q, k_d;
  logic [dhtt_pkg::IDX_W-1:0]    rn_q, rn_d;
  logic [dhtt_pkg::PRES_W-1:0]   rp_q, rp_d;

  // shift the key out msb first and fold both remainders
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    k_d    = k_q;
    rn_d   = rn_q;
    rp_d   = rp_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      k_d   = dhtt_pkg::HKEY_W'(key_i);
      rn_d  = '0;
      rp_d  = '0;
    end else if (run_q) begin
      rn_d  = dhtt_pkg::mod_n_step(rn_q, k_q[dhtt_pkg::HKEY_W-1 -: 2]);
      rp_d  = dhtt_pkg::mod_p_step(rp_q, k_q[dhtt_pkg::HKEY_W-1 -: 2]);
      k_d   = {k_q[dhtt_pkg::HKEY_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dhtt_pkg::HCNT_W'(dhtt_pkg::HASH_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    k_q  <= k_d;
    rn_q <= rn_d;
    rp_q <= rp_d;
  end

  assign hash_o.done = done_q;
  assign hash_o.home = rn_q;
  assign hash_o.step = dhtt_pkg::STEP_W'(dhtt_pkg::STEP_PRIME) - dhtt_pkg::STEP_W'(rp_q);

endmodule

// ===== hdl/dhtt_store.sv =====
// slot store: status flops cleared at reset, key and value memory
`timescale 1ns / 1ps

module dhtt_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dhtt_pkg::wr_t              wr_i,
  input  logic [dhtt_pkg::IDX_W-1:0] rd_addr_i,
  output dhtt_pkg::rd_t              rd_o
);

  logic [1:0]                 status_q [dhtt_pkg::TABLE_SIZE];
  logic [dhtt_pkg::KEY_W-1:0]  key_mem  [dhtt_pkg::TABLE_SIZE];
  logic [dhtt_pkg::ELEM_W-1:0] val_mem  [dhtt_pkg::TABLE_SIZE];
  dhtt_pkg::rd_t               rd_q;

  // slot status, all never used after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dhtt_pkg::TABLE_SIZE; i++) begin
        status_q[i] <= dhtt_pkg::SLOT_NEVER;
      end
    end else if (wr_i.st_we) begin
      status_q[wr_i.addr] <= wr_i.status;
    end
  end

  // key and value memory
  always_ff @(posedge clk_i) begin
    if (wr_i.kv_we) begin
      key_mem[wr_i.addr] <= wr_i.key;
      val_mem[wr_i.addr] <= wr_i.value;
    end
  end

  // registered read of one slot
  always_ff @(posedge clk_i) begin
    rd_q.status <= status_q[rd_addr_i];
    rd_q.key    <= key_mem[rd_addr_i];
    rd_q.value  <= val_mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule

// ===== hdl/double_hash_table_tombstone_core.sv =====
// double hashing key/value table with tombstones, top level
//
//   channel | direction | handshake             | payload
//   in      | to core   | in_valid_i/in_stall_o | in_req_i  (func, key, elem_in)
//   out     | from core | out_valid_o/out_stall_i | out_rsp_o (status, elem_out)
//
// one request at a time: the key is hashed first, then one slot read per
// cycle along the probe path (up to TABLE_SIZE+1), and for an insert a
// second walk of the same length. the single store read port and the
// two-bit-per-cycle hash unit set the pace.
// reset clears every slot to never used at once; no clearing pass.
// a held result does not block the next request, only its completion.
`timescale 1ns / 1ps
`include "double_hash_table_tombstone_core_assert.svh"

module double_hash_table_tombstone_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dhtt_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dhtt_pkg::rsp_t out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  dhtt_pkg::req_t                req_q, req_d;
  logic [dhtt_pkg::IDX_W-1:0]    home_q, home_d;
  logic [dhtt_pkg::STEP_W-1:0]   step_q, step_d;
  logic [dhtt_pkg::IDX_W-1:0]    pos_q, pos_d;
  logic [dhtt_pkg::CNT_W-1:0]    count_q, count_d;
  dhtt_pkg::rsp_t                res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  dhtt_pkg::rsp_t                out_rsp_q, out_rsp_d;

  dhtt_pkg::hash_t               hash;
  dhtt_pkg::wr_t                 wr;
  dhtt_pkg::rd_t                 rd;
  logic                          accept;
  logic                          probes_done;
  logic                          hit;
  logic [dhtt_pkg::IDX_W-1:0]    pos_adv;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign probes_done = (count_q == dhtt_pkg::CNT_W'(dhtt_pkg::TABLE_SIZE));
  assign hit         = (rd.status == dhtt_pkg::SLOT_OCCUPIED) && (rd.key == req_q.key);
  assign pos_adv     = dhtt_pkg::next_pos(pos_q, step_q);

  dhtt_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .key_i  (in_req_i.key),
    .hash_o (hash)
  );

  // read data always belongs to the slot at pos_q
  dhtt_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_addr_i(pos_d),
    .rd_o     (rd)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    home_d      = home_q;
    step_d      = step_q;
    pos_d       = pos_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    wr.st_we    = 1'b0;
    wr.kv_we    = 1'b0;
    wr.addr     = pos_q;
    wr.status   = dhtt_pkg::SLOT_OCCUPIED;
    wr.key      = req_q.key;
    wr.value    = req_q.elem_in;

    // result taken downstream
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = in_req_i;
          state_d = S_HASH;
        end
      end

      S_HASH: begin
        if (hash.done) begin
          home_d  = hash.home;
          step_d  = hash.step;
          pos_d   = hash.home;
          count_d = '0;
          state_d = S_SCAN;
        end
      end

      // search walk
      S_SCAN: begin
        res_d.status   = dhtt_pkg::RES_NOT_FOUND;
        res_d.elem_out = '0;
        state_d        = S_DONE;
        case (req_q.func)
          dhtt_pkg::FUNC_FIND: begin
            if (probes_done) begin
              res_d.status = dhtt_pkg::RES_FULL;
            end else if (rd.status == dhtt_pkg::SLOT_NEVER) begin
              res_d.status = dhtt_pkg::RES_NOT_FOUND;
            end else if (hit) begin
              res_d.status   = dhtt_pkg::RES_OK;
              res_d.elem_out = rd.value;
            end else begin
              pos_d   = pos_adv;
              count_d = count_q + 1'b1;
              state_d = S_SCAN;
            end
          end
          dhtt_pkg::FUNC_INSERT: begin
            if (probes_done) begin
              res_d.status = dhtt_pkg::RES_FULL;
            end else if (rd.status == dhtt_pkg::SLOT_NEVER) begin
              // restart from home to find the first free slot
              pos_d   = home_q;
              count_d = '0;
              state_d = S_PLACE;
            end else if (hit) begin
              res_d.status = dhtt_pkg::RES_DUPLICATE;
            end else begin
              pos_d   = pos_adv;
              count_d = count_q + 1'b1;
              state_d = S_SCAN;
            end
          end
          dhtt_pkg::FUNC_REMOVE: begin
            if (probes_done || rd.status == dhtt_pkg::SLOT_NEVER) begin
              res_d.status = dhtt_pkg::RES_NOT_FOUND;
            end else if (hit) begin
              res_d.status   = dhtt_pkg::RES_OK;
              res_d.elem_out = rd.value;
              wr.st_we       = 1'b1;
              wr.status      = dhtt_pkg::SLOT_DELETED;
            end else begin
              pos_d   = pos_adv;
              count_d = count_q + 1'b1;
              state_d = S_SCAN;
            end
          end
          default: begin
            // unused operation code: no change, not found
            res_d.status = dhtt_pkg::RES_NOT_FOUND;
          end
        endcase
      end

      // placement walk for insert
      S_PLACE: begin
        res_d.elem_out = '0;
        if (probes_done) begin
          res_d.status = dhtt_pkg::RES_FULL;
          state_d      = S_DONE;
        end else if (rd.status != dhtt_pkg::SLOT_OCCUPIED) begin
          wr.st_we     = 1'b1;
          wr.kv_we     = 1'b1;
          res_d.status = dhtt_pkg::RES_OK;
          state_d      = S_DONE;
        end else begin
          pos_d   = pos_adv;
          count_d = count_q + 1'b1;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      home_q      <= '0;
      step_q      <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      home_q      <= home_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // checks
  `DHTT_ASSERT_CLK(a_write_ends_request, (wr.st_we |=> state_q == S_DONE), "store write not followed by result")
  `DHTT_ASSERT_CLK(a_hash_done_in_hash, (hash.done |-> state_q == S_HASH), "hash finished outside hash phase")
  `DHTT_ASSERT_CLK(a_probe_bound, (count_q <= dhtt_pkg::CNT_W'(dhtt_pkg::TABLE_SIZE)), "probe count past table size")
  `DHTT_ASSERT_CLK(a_result_from_done, ($rose(out_valid_o) |-> $past(state_q) == S_DONE), "result raised outside done")
  `DHTT_ASSERT_RST(a_no_result_in_reset, (!rst_ni |-> !out_valid_o), "result valid during reset")

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the double hashing key/value table core
`timescale 1ns / 1ps

module testbench;
  import dhtt_pkg::*;

  // func code with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int  RESET_CYCLES = 6;
  localparam int  MAX_GAP      = 6;
  localparam int  RANDOM_ITEMS = 1450;
  localparam int  WARMUP_ITEMS = 500;
  localparam int  HOLD_AT_RSP  = 300;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  TAIL_CYCLES  = 150;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  MAX_PRINTS   = 40;
  localparam int  POOL_SIZE    = 48;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct {
    req_t req;
    int   gap;
    bit   drain;
  } queued_req_t;

  typedef struct {
    req_t req;
    rsp_t rsp;
  } table_ans_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b1;
  logic in_valid_i  = 1'b0;
  req_t in_req_i    = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // shadow copy of the slot store
  logic [1:0]        shadow_st  [TABLE_SIZE];
  logic [KEY_W-1:0]  shadow_key [TABLE_SIZE];
  logic [ELEM_W-1:0] shadow_val [TABLE_SIZE];

  queued_req_t       req_backlog[$];
  table_ans_t        table_ans_q[$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int  mismatch_cnt = 0;
  int  req_sent     = 0;
  int  rsp_seen     = 0;
  int  cycle_cnt    = 0;
  int  status_cnt [4];
  int  idle_cnt     = 0;
  int  stall_left   = 0;
  int  hold_left    = 0;
  bit  hold_go      = 1'b0;
  bit  held_once    = 1'b0;

  double_hash_table_tombstone_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // walk the probe path of a key over the shadow store
  function automatic logic [1:0] probe_shadow(input logic [KEY_W-1:0] k, output int hit_idx);
    int unsigned ku;
    int pos;
    int step;
    int n;
    ku = 32'(k);
    pos = ku % TABLE_SIZE;
    step = STEP_PRIME - (ku % STEP_PRIME);
    n = 0;
    hit_idx = 0;
    while (n < TABLE_SIZE && shadow_st[pos] != SLOT_NEVER) begin
      if (shadow_st[pos] == SLOT_OCCUPIED && shadow_key[pos] == k) begin
        hit_idx = pos;
        return RES_OK;
      end
      pos = (pos + step) % TABLE_SIZE;
      n++;
    end
    return (n == TABLE_SIZE) ? RES_FULL : RES_NOT_FOUND;
  endfunction

  // apply one operation to the shadow store and return the expected answer
  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t a;
    logic [1:0] srch;
    int hit;
    int unsigned ku;
    int pos;
    int step;
    int n;
    a.status = RES_NOT_FOUND;
    a.elem_out = '0;
    ku = 32'(r.key);
    case (r.func)
      FUNC_FIND: begin
        srch = probe_shadow(r.key, hit);
        a.status = srch;
        if (srch == RES_OK) a.elem_out = shadow_val[hit];
      end
      FUNC_INSERT: begin
        srch = probe_shadow(r.key, hit);
        if (srch == RES_OK) begin
          a.status = RES_DUPLICATE;
        end else if (srch == RES_FULL) begin
          a.status = RES_FULL;
        end else begin
          // first never-used or deleted slot on the path
          pos = ku % TABLE_SIZE;
          step = STEP_PRIME - (ku % STEP_PRIME);
          n = 0;
          while (n < TABLE_SIZE && shadow_st[pos] == SLOT_OCCUPIED) begin
            pos = (pos + step) % TABLE_SIZE;
            n++;
          end
          if (n < TABLE_SIZE) begin
            shadow_st[pos]  = SLOT_OCCUPIED;
            shadow_key[pos] = r.key;
            shadow_val[pos] = r.elem_in;
            a.status = RES_OK;
          end else begin
            a.status = RES_FULL;
          end
        end
      end
      FUNC_REMOVE: begin
        srch = probe_shadow(r.key, hit);
        if (srch == RES_OK) begin
          a.elem_out = shadow_val[hit];
          shadow_st[hit] = SLOT_DELETED;
          a.status = RES_OK;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_req(input logic [1:0] f, input logic [KEY_W-1:0] k,
                           input logic [ELEM_W-1:0] v, input bit drain);
    queued_req_t q;
    q.req.func = f;
    q.req.key = k;
    q.req.elem_in = v;
    q.drain = drain;
    // every fifth block of 64 requests goes back to back
    q.gap = (((req_backlog.size() / 64) % 5) == 3) ? 0 : $urandom_range(0, MAX_GAP);
    req_backlog.push_back(q);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int span);
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  function automatic logic [1:0] pick_func(input bit warmup);
    int r;
    r = $urandom_range(0, 99);
    if (r < (warmup ? 45 : 35)) return FUNC_INSERT;
    if (r < 65) return FUNC_FIND;
    if (r < 95) return FUNC_REMOVE;
    return FUNC_UNUSED;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic nxt_valid;
    req_t nxt_req;
    int   nxt_idle;
    table_ans_t ans;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      idle_cnt   <= 0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_req   = in_req_i;
      nxt_idle  = idle_cnt;
      if (in_valid_i && !in_stall_o) begin
        ans.req = in_req_i;
        ans.rsp = apply_table_op(in_req_i);
        status_cnt[ans.rsp.status]++;
        table_ans_q.push_back(ans);
        req_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && req_backlog.size() > 0) begin
        if (req_backlog[0].drain && table_ans_q.size() > 0) begin
          // wait for every outstanding answer
        end else if (nxt_idle < req_backlog[0].gap) begin
          nxt_idle++;
        end else begin
          nxt_valid = 1'b1;
          nxt_req   = req_backlog[0].req;
          nxt_idle  = 0;
          req_backlog.pop_front();
        end
      end
      in_valid_i <= nxt_valid;
      in_req_i   <= nxt_req;
      idle_cnt   <= nxt_idle;
    end
  end

  // long hold-off timer for the response side
  always @(posedge clk_i or negedge rst_ni) begin : hold_timer
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    int sl;
    bit hg;
    table_ans_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_go     <= 1'b0;
    end else begin
      sl = stall_left;
      hg = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        if (table_ans_q.size() == 0) begin
          flag_mismatch($sformatf("response with nothing expected: status %0d elem %0h",
                                  out_rsp_o.status, out_rsp_o.elem_out));
        end else begin
          e = table_ans_q.pop_front();
          if (out_rsp_o.status !== e.rsp.status)
            flag_mismatch($sformatf("func %0d key %0h: status %0d, expected %0d",
                                    e.req.func, e.req.key, out_rsp_o.status, e.rsp.status));
          if (out_rsp_o.elem_out !== e.rsp.elem_out)
            flag_mismatch($sformatf("func %0d key %0h: elem %0h, expected %0h",
                                    e.req.func, e.req.key, out_rsp_o.elem_out,
                                    e.rsp.elem_out));
        end
        rsp_seen++;
        // one long hold-off so the core backs up into its input
        if (rsp_seen == HOLD_AT_RSP && !held_once) begin
          hg = 1'b1;
          held_once <= 1'b1;
        end
        sl = (((rsp_seen / 128) % 5) == 2) ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid_o && sl > 0) begin
        sl--;
      end
      out_stall_i <= hg || hold_go || (hold_left > 0) || (sl > 0);
      stall_left  <= sl;
      hold_go     <= hg;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_cnt,
               table_ans_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [ELEM_W-1:0] alt_a;
    logic [ELEM_W-1:0] alt_b;
    rst_ni <= 1'b0;
    alt_a = ELEM_W'({(ELEM_W+1)/2{2'b01}});
    alt_b = ~alt_a;
    for (int i = 0; i < TABLE_SIZE; i++) shadow_st[i] = SLOT_NEVER;
    for (int i = 0; i < 4; i++) status_cnt[i] = 0;

    // key pool: shared home slot, near the top, shared home and step, random
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0:       key_pool[i] = KEY_W'(3 + TABLE_SIZE * i);
        1:       key_pool[i] = KEY_MAX - KEY_W'(i);
        2:       key_pool[i] = KEY_W'(5 + TABLE_SIZE * STEP_PRIME * i);
        default: key_pool[i] = KEY_W'($urandom);
      endcase
    end

    // directed: empty table, extremes, duplicates, tombstones, unused func
    queue_req(FUNC_FIND,   KEY_W'(5), alt_a, 1'b0);
    queue_req(FUNC_REMOVE, KEY_W'(5), alt_b, 1'b0);
    queue_req(FUNC_UNUSED, KEY_MAX, {ELEM_W{1'b1}}, 1'b0);
    queue_req(FUNC_INSERT, '0, {ELEM_W{1'b1}}, 1'b0);
    queue_req(FUNC_INSERT, KEY_MAX, '0, 1'b0);
    queue_req(FUNC_FIND,   '0, alt_a, 1'b0);
    queue_req(FUNC_FIND,   KEY_MAX, alt_b, 1'b0);
    queue_req(FUNC_INSERT, '0, alt_a, 1'b0);
    queue_req(FUNC_INSERT, KEY_W'(TABLE_SIZE), alt_a, 1'b0);
    queue_req(FUNC_INSERT, KEY_W'(TABLE_SIZE * STEP_PRIME), alt_b, 1'b0);
    queue_req(FUNC_REMOVE, '0, '0, 1'b0);
    queue_req(FUNC_FIND,   '0, '0, 1'b0);
    queue_req(FUNC_FIND,   KEY_W'(TABLE_SIZE * STEP_PRIME), '0, 1'b0);
    queue_req(FUNC_INSERT, KEY_W'(2 * TABLE_SIZE), alt_b, 1'b0);
    queue_req(FUNC_REMOVE, '0, alt_a, 1'b0);
    queue_req(FUNC_UNUSED, '0, alt_a, 1'b0);
    queue_req(FUNC_FIND,   KEY_W'(2 * TABLE_SIZE), '0, 1'b0);
    queue_req(FUNC_REMOVE, KEY_W'(TABLE_SIZE), '0, 1'b0);
    queue_req(FUNC_REMOVE, KEY_W'(TABLE_SIZE), '0, 1'b0);
    queue_req(FUNC_REMOVE, KEY_MAX, alt_a, 1'b0);

    // random: small key set first so the table cycles through tombstones,
    // then the full pool which drives it into the full state
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < WARMUP_ITEMS)
        queue_req(pick_func(1'b1), pick_key(12), ELEM_W'($urandom), i == 0);
      else
        queue_req(pick_func(1'b0), pick_key(POOL_SIZE), ELEM_W'($urandom),
                  i == WARMUP_ITEMS || i == 1000);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() > 0 || in_valid_i || table_ans_q.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (table_ans_q.size() > 0)
      flag_mismatch($sformatf("%0d answers never arrived", table_ans_q.size()));

    $display("run covered %0d requests and %0d responses over %0d cycles",
             req_sent, rsp_seen, cycle_cnt);
    $display("answers: ok %0d, not found %0d, duplicate %0d, full %0d; mismatches %0d",
             status_cnt[RES_OK], status_cnt[RES_NOT_FOUND], status_cnt[RES_DUPLICATE],
             status_cnt[RES_FULL], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dhtt_pkg.sv
hdl/dhtt_hash.sv
hdl/dhtt_store.sv
hdl/double_hash_table_tombstone_core.sv
sim/testbench.sv
